[hw/rtl/pse_pkg.sv]
// Shared types, sizing constants and reset values for the power step event detector.
package pse_pkg;

    // Samples per window (baseline and candidate alike).
    localparam int WINDOW = 16;
    localparam int LOG_W  = $clog2(WINDOW);

    // A window sum is at most WINDOW * 65535.
    localparam int SUM_W  = 16 + LOG_W;
    localparam int FILL_W = $clog2(WINDOW + 1);

    // Divide by WINDOW as a multiply by a rounded-up reciprocal; exact for
    // every dividend below 2**SUM_W.
    localparam int                DIV_K   = SUM_W + LOG_W;
    localparam longint unsigned   DIV_M_L = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;
    localparam logic [SUM_W:0]    DIV_M   = DIV_M_L[SUM_W:0];
    localparam int                PROD_W  = 2 * SUM_W + 1;

    // Step threshold after reset: 30 VA in Q12.4.
    localparam logic [15:0] RESET_THR = 16'd480;

    typedef logic [15:0]      t_sample;
    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [15:0] power_sample;
        logic [31:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic [31:0] event_time;
        logic [15:0] step_size;
        logic        turned_on;
    } t_out_item;

    // Per-cycle command to every cell of the window line.
    typedef struct packed {
        logic shift_base;
        logic shift_cand;
        logic swap;
    } t_cell_ctl;

    // Confirmed window swap waiting for the threshold check and scaling.
    typedef struct packed {
        logic [31:0] event_time;
        t_sum        diff;
        logic        up;
    } t_event;

endpackage

[hw/rtl/pse_cell.sv]
// One slot of the window line: a baseline entry and a candidate entry.
module pse_cell (
    input  logic               i_clk,
    input  pse_pkg::t_cell_ctl i_ctl,
    input  pse_pkg::t_sample   i_base,
    input  pse_pkg::t_sample   i_cand,
    output pse_pkg::t_sample   o_base,
    output pse_pkg::t_sample   o_cand
);
    import pse_pkg::*;

    t_sample r_base, n_base;
    t_sample r_cand, n_cand;

    always_comb begin
        n_cand = i_ctl.shift_cand ? i_cand : r_cand;
        // On a swap the freshly shifted candidate entry becomes the baseline entry.
        if (i_ctl.shift_base) begin
            n_base = i_base;
        end else if (i_ctl.swap) begin
            n_base = n_cand;
        end else begin
            n_base = r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_cand <= n_cand;
    end

    assign o_base = r_base;
    assign o_cand = r_cand;

endmodule

[hw/rtl/power_step_event_detector.sv]
// Top level of the power step event detector: window line, sums, control and result queue.
//
// The detector takes one power request per clock cycle and reports confirmed
// step changes in mean apparent power. A line of WINDOW cells holds the
// baseline window and the candidate window side by side; a new sample enters
// at cell 0 and the oldest baseline entry leaves at the last cell, so the
// sums are kept with one add and one subtract per sample. Once the baseline
// is full, a sample farther than step_threshold from the baseline mean is
// dropped, its timestamp is latched, and the next WINDOW samples fill the
// candidate window. When that window is full every cell copies its candidate
// entry into its baseline entry in the same cycle, and if the two means differ
// by more than step_threshold one result comes out with the latched time, the
// truncated mean difference and the direction. The sample that completes the
// candidate window latches the sum difference in the event register; it is
// then compared and divided by WINDOW (a multiply by a constant reciprocal)
// into the output register. The input side stalls only when both the event
// register and the output register are full and the output is not taken.
// Write step_threshold only while the block is idle.
module power_step_event_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pse_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import pse_pkg::*;

    // Control and sums
    logic              r_confirming, n_confirming;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_sum              r_base_sum, n_base_sum;
    t_sum              r_cand_sum, n_cand_sum;
    t_sum              r_limit, n_limit;
    logic [31:0]       r_pend_time, n_pend_time;

    // Event register and output register
    t_event            r_ev, n_ev;
    logic              r_ev_valid, n_ev_valid;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              in_fire;
    logic              out_free;
    logic              ev_move;
    logic              ev_keep;
    logic              full;
    logic              trigger;
    logic              done;
    t_sum              samp_ext;
    t_sum              scaled;
    t_sum              samp_dist;
    t_sum              cand_new;
    t_sum              base_upd;
    logic [FILL_W-1:0] fill_inc;
    logic [PROD_W-1:0] prod;
    t_cell_ctl         cell_ctl;

    t_sample           base_q [0:WINDOW-1];
    t_sample           cand_q [0:WINDOW-2];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign out_free    = !r_out_valid || i_out_ready;
    assign ev_move     = r_ev_valid && out_free;
    assign o_in_ready  = !r_ev_valid || out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sample tests and sum updates
    // ------------------------------------------------------------------
    assign samp_ext  = t_sum'(i_in_data.power_sample);
    // Compare on sums: |x*WINDOW - sum| > threshold*WINDOW.
    assign scaled    = samp_ext * t_sum'(WINDOW);
    assign samp_dist = (scaled > r_base_sum) ? (scaled - r_base_sum) : (r_base_sum - scaled);
    assign full      = (r_fill == FILL_W'(WINDOW));
    assign trigger   = !r_confirming && full && (samp_dist > r_limit);
    assign fill_inc  = r_fill + FILL_W'(1);
    assign done      = r_confirming && (fill_inc == FILL_W'(WINDOW));
    assign cand_new  = r_cand_sum + samp_ext;
    // Drop the oldest baseline entry from the sum only once the window is full.
    assign base_upd  = (r_base_sum - (full ? t_sum'(base_q[WINDOW-1]) : '0)) + samp_ext;

    assign cell_ctl.shift_base = in_fire && !r_confirming && !trigger;
    assign cell_ctl.shift_cand = in_fire && r_confirming;
    assign cell_ctl.swap       = in_fire && done;

    // ------------------------------------------------------------------
    // Window line
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
        if (gi == 0 && WINDOW > 1) begin : g_head
            pse_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_base (i_in_data.power_sample),
                .i_cand (i_in_data.power_sample),
                .o_base (base_q[gi]),
                .o_cand (cand_q[gi])
            );
        end else if (gi < WINDOW - 1) begin : g_mid
            pse_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_base (base_q[gi-1]),
                .i_cand (cand_q[gi-1]),
                .o_base (base_q[gi]),
                .o_cand (cand_q[gi])
            );
        end else begin : g_tail
            // Tail cell: its baseline entry is the oldest one.
            pse_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_base (base_q[gi-1]),
                .i_cand (cand_q[gi-1]),
                .o_base (base_q[gi]),
                .o_cand ()
            );
        end
    end

    // ------------------------------------------------------------------
    // Control next state
    // ------------------------------------------------------------------
    always_comb begin
        n_confirming = r_confirming;
        n_fill       = r_fill;
        n_base_sum   = r_base_sum;
        n_cand_sum   = r_cand_sum;
        n_pend_time  = r_pend_time;
        n_ev         = r_ev;
        n_ev_valid   = r_ev_valid && !ev_move;
        n_limit      = r_limit;

        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = t_sum'(i_cfg_data) * t_sum'(WINDOW);
        end

        if (in_fire) begin
            if (!r_confirming) begin
                if (trigger) begin
                    // Drop the trigger sample, latch its time, open the candidate.
                    n_confirming = 1'b1;
                    n_cand_sum   = '0;
                    n_fill       = '0;
                    n_pend_time  = i_in_data.sample_time;
                end else begin
                    n_base_sum = base_upd;
                    if (!full) begin
                        n_fill = fill_inc;
                    end
                end
            end else if (done) begin
                // Candidate full: it becomes the baseline, queue the comparison.
                n_base_sum      = cand_new;
                n_fill          = FILL_W'(WINDOW);
                n_confirming    = 1'b0;
                n_ev_valid      = 1'b1;
                n_ev.event_time = r_pend_time;
                n_ev.up         = cand_new > r_base_sum;
                n_ev.diff       = (cand_new > r_base_sum) ? (cand_new - r_base_sum)
                                                          : (r_base_sum - cand_new);
            end else begin
                n_cand_sum = cand_new;
                n_fill     = fill_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: threshold check and divide by WINDOW
    // ------------------------------------------------------------------
    assign prod    = PROD_W'(r_ev.diff) * PROD_W'(DIV_M);
    assign ev_keep = r_ev.diff > r_limit;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = ev_move && ev_keep;
        end
        if (ev_move && ev_keep) begin
            n_out.event_time = r_ev.event_time;
            n_out.step_size  = prod[DIV_K +: 16];
            n_out.turned_on  = r_ev.up;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirming <= 1'b0;
            r_fill       <= '0;
            r_base_sum   <= '0;
            r_cand_sum   <= '0;
            r_pend_time  <= '0;
            r_limit      <= t_sum'(RESET_THR) * t_sum'(WINDOW);
            r_ev_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_confirming <= n_confirming;
            r_fill       <= n_fill;
            r_base_sum   <= n_base_sum;
            r_cand_sum   <= n_cand_sum;
            r_pend_time  <= n_pend_time;
            r_limit      <= n_limit;
            r_ev_valid   <= n_ev_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev  <= n_ev;
        r_out <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count beyond window size");

    a_out_from_event : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_ev_valid))
        else $error("result without a queued event");

    a_swap_queues : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_confirming) |-> r_ev_valid)
        else $error("candidate closed without queueing an event");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_ev_valid && r_out_valid))
        else $error("input stalled with free event or output register");

endmodule
